@@ sv/linear_probe_hash_table_top_assert.svh @@
// Assertion macros shared by the hash table RTL
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define LPHT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define LPHT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/lpht_pkg.sv @@
// Shared types, constants and helpers of the linear probe hash table
package lpht_pkg;

  // Parameter defaults
  localparam int unsigned TABLE_DEPTH_DEF = 64;
  localparam int unsigned NAME_BYTES_DEF  = 8;

  // Fixed field widths
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned PHONE_W   = 40;
  localparam int unsigned SIZE_W    = 7;   // table_size register
  localparam int unsigned SUM_W     = 11;  // sum of up to eight bytes
  localparam int unsigned OUT_IDX_W = 6;   // comparisons, slot_index
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 1;

  // Request modes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE   = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_HMOD,
    S_READ,
    S_CHECK,
    S_OMOD,
    S_DONE
  } lpht_state_t;

  // Request to the shared modulo unit
  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  dividend;
    logic [SIZE_W-1:0] divisor;
  } mod_req_t;

  // Sum of the low nb bytes of a name
  function automatic logic [SUM_W-1:0] byte_sum(input logic [KEY_W-1:0] name,
                                                input int unsigned nb);
    logic [SUM_W-1:0] acc;
    acc = '0;
    for (int unsigned b = 0; b < 8; b++) begin
      if (b < nb) begin
        acc = acc + SUM_W'(name[8*b +: 8]);
      end
    end
    return acc;
  endfunction

endpackage

@@ sv/lpht_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module lpht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/lpht_mod.sv @@
// Shared radix-2 restoring modulo unit: byte sum modulo table size
module lpht_mod (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lpht_pkg::mod_req_t           req,
  output logic                         done,
  output logic [lpht_pkg::SIZE_W-1:0]  rem
);

  localparam int unsigned CNT_W = $clog2(lpht_pkg::SUM_W);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [lpht_pkg::SUM_W-1:0]   dvd_r, dvd_nxt;
  logic [lpht_pkg::SIZE_W-1:0]  div_r, div_nxt;
  logic [lpht_pkg::SIZE_W-1:0]  rem_r, rem_nxt;
  logic [lpht_pkg::SIZE_W:0]    trial;

  // One quotient bit per cycle, dividend MSB first
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[lpht_pkg::SUM_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(lpht_pkg::SUM_W - 1);
      dvd_nxt  = req.dividend;
      div_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = lpht_pkg::SIZE_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = lpht_pkg::SIZE_W'(trial);
      end
      dvd_nxt = {dvd_r[lpht_pkg::SUM_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Operands and partial remainder
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

@@ sv/linear_probe_hash_table_top.sv @@
// Top level of the linear probe hash table: sequencer, slot valid bits, datapath
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------------------
//   in_     | in        | in_valid / in_stall    | mode, key_name, phone_number
//   out_    | out       | out_valid / out_stall  | status, found_phone, comparisons, slot_index
//   cfg_    | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One request at a time. The home slot comes from the shared modulo unit, started when
// the request is accepted. Each probe then reads one slot; in replacement mode an occupied
// slot runs the modulo unit again for its occupant.
// Reset (rst_n, synchronous) empties the table and sets the registers to their defaults.
// A finished result waits in the output register under out_stall; the next request is
// taken meanwhile, and its own result waits until that register frees up.
`include "linear_probe_hash_table_top_assert.svh"

module linear_probe_hash_table_top #(
  parameter int unsigned TABLE_DEPTH = lpht_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned NAME_BYTES  = lpht_pkg::NAME_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_mode,
  input  logic [lpht_pkg::KEY_W-1:0]      in_key_name,
  input  logic [lpht_pkg::PHONE_W-1:0]    in_phone_number,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lpht_pkg::STATUS_W-1:0]   out_status,
  output logic [lpht_pkg::PHONE_W-1:0]    out_found_phone,
  output logic [lpht_pkg::OUT_IDX_W-1:0]  out_comparisons,
  output logic [lpht_pkg::OUT_IDX_W-1:0]  out_slot_index,
  // configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lpht_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpht_pkg::SIZE_W-1:0]     cfg_data
);

  // The 7-bit size register caps the slots in use
  localparam int unsigned SLOTS  = (TABLE_DEPTH < 127) ? TABLE_DEPTH : 127;
  localparam int unsigned AW     = $clog2(SLOTS);
  localparam int unsigned NAME_W = 8 * NAME_BYTES;
  localparam int unsigned DATA_W = NAME_W + lpht_pkg::PHONE_W;
  localparam int unsigned SW     = lpht_pkg::SIZE_W;
  localparam int unsigned SIZE_RST_I =
    ((TABLE_DEPTH % 128) == 0) ? 64 : (TABLE_DEPTH % 128);
  localparam logic [SW-1:0] SIZE_RST = SW'(SIZE_RST_I);
  localparam logic [SW-1:0] SLOTS_SZ = SW'(SLOTS);

  lpht_pkg::lpht_state_t state_r, state_nxt;

  // Configuration
  logic          replace_r;
  logic [SW-1:0] tsize_r;

  // Request context
  logic                          mode_r;
  logic [NAME_W-1:0]             c_name_r;
  logic [lpht_pkg::PHONE_W-1:0]  c_phone_r;
  logic [SW-1:0]                 c_home_r;
  logic [NAME_W-1:0]             occ_name_r;
  logic [lpht_pkg::PHONE_W-1:0]  occ_phone_r;
  logic [SW-1:0]                 size_r;
  logic [SW-1:0]                 k_r;
  logic [AW-1:0]                 idx_r;
  logic [SLOTS-1:0]              valid_r;

  // Pending result
  logic [lpht_pkg::STATUS_W-1:0]  res_status_r;
  logic [lpht_pkg::PHONE_W-1:0]   res_phone_r;
  logic [lpht_pkg::OUT_IDX_W-1:0] res_comps_r;
  logic [lpht_pkg::OUT_IDX_W-1:0] res_slot_r;

  // Output register
  logic                           out_valid_r;
  logic [lpht_pkg::STATUS_W-1:0]  out_status_r;
  logic [lpht_pkg::PHONE_W-1:0]   out_phone_r;
  logic [lpht_pkg::OUT_IDX_W-1:0] out_comps_r;
  logic [lpht_pkg::OUT_IDX_W-1:0] out_slot_r;

  // Datapath wires
  logic                          accept;
  logic                          out_free;
  logic [SW-1:0]                 used_size;
  logic [SW-1:0]                 idx_ext;
  logic [AW-1:0]                 idx_nxt;
  logic                          last;
  logic                          cur_valid;
  logic                          hit;
  logic                          chk_step;
  logic                          swap;
  logic [NAME_W-1:0]             rd_name;
  logic [lpht_pkg::PHONE_W-1:0]  rd_phone;
  logic                          ram_we;
  logic [AW-1:0]                 ram_raddr;
  logic [DATA_W-1:0]             ram_rdata;
  lpht_pkg::mod_req_t            mod_req;
  logic                          mod_done;
  logic [SW-1:0]                 mod_rem;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != lpht_pkg::S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Size in use: zero acts as one, capped at the slot count
  always_comb begin
    if (tsize_r == '0) begin
      used_size = SW'(1);
    end else if (tsize_r > SLOTS_SZ) begin
      used_size = SLOTS_SZ;
    end else begin
      used_size = tsize_r;
    end
  end

  // Probe position and slot checks
  assign idx_ext   = SW'(idx_r);
  assign idx_nxt   = ((idx_ext + SW'(1)) == size_r) ? '0 : (idx_r + AW'(1));
  assign last      = ((k_r + SW'(1)) == size_r);
  assign rd_name   = ram_rdata[lpht_pkg::PHONE_W +: NAME_W];
  assign rd_phone  = ram_rdata[lpht_pkg::PHONE_W-1:0];
  assign cur_valid = valid_r[idx_r];
  assign hit       = cur_valid && (rd_name == c_name_r);
  assign swap      = (mod_rem != c_home_r);
  assign chk_step  = (state_r == lpht_pkg::S_CHECK) && !last &&
                     (((mode_r == lpht_pkg::MODE_INSERT) && cur_valid && !replace_r) ||
                      ((mode_r == lpht_pkg::MODE_SEARCH) && !hit));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lpht_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = lpht_pkg::S_HMOD;
        end
      end
      lpht_pkg::S_HMOD: begin
        if (mod_done) begin
          state_nxt = lpht_pkg::S_READ;
        end
      end
      lpht_pkg::S_READ: begin
        state_nxt = lpht_pkg::S_CHECK;
      end
      lpht_pkg::S_CHECK: begin
        if (mode_r == lpht_pkg::MODE_INSERT) begin
          if (!cur_valid) begin
            state_nxt = lpht_pkg::S_DONE;
          end else if (replace_r) begin
            state_nxt = lpht_pkg::S_OMOD;
          end else if (last) begin
            state_nxt = lpht_pkg::S_DONE;
          end
        end else if (hit || last) begin
          state_nxt = lpht_pkg::S_DONE;
        end
      end
      lpht_pkg::S_OMOD: begin
        if (mod_done) begin
          state_nxt = last ? lpht_pkg::S_DONE : lpht_pkg::S_READ;
        end
      end
      lpht_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = lpht_pkg::S_IDLE;
        end
      end
      default: state_nxt = lpht_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs: modulo requests, RAM ports
  always_comb begin
    mod_req.start    = 1'b0;
    mod_req.dividend = lpht_pkg::byte_sum(lpht_pkg::KEY_W'(rd_name), NAME_BYTES);
    mod_req.divisor  = size_r;
    ram_we           = 1'b0;
    ram_raddr        = chk_step ? idx_nxt : idx_r;
    unique case (state_r)
      lpht_pkg::S_IDLE: begin
        mod_req.start    = accept;
        mod_req.dividend = lpht_pkg::byte_sum(in_key_name, NAME_BYTES);
        mod_req.divisor  = used_size;
      end
      lpht_pkg::S_CHECK: begin
        if (mode_r == lpht_pkg::MODE_INSERT) begin
          ram_we        = !cur_valid;
          mod_req.start = cur_valid && replace_r;
        end
      end
      lpht_pkg::S_OMOD: begin
        ram_we = mod_done && swap;
      end
      lpht_pkg::S_HMOD, lpht_pkg::S_READ, lpht_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpht_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      replace_r <= 1'b0;
      tsize_r   <= SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lpht_pkg::CFG_REPLACE_MODE: replace_r <= cfg_data[0];
        lpht_pkg::CFG_TABLE_SIZE:   tsize_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Slot valid bits: set on the write into an empty slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if ((state_r == lpht_pkg::S_CHECK) && ram_we) begin
      valid_r[idx_r] <= 1'b1;
    end
  end

  // Request context and probe walk
  always_ff @(posedge clk) begin
    unique case (state_r)
      lpht_pkg::S_IDLE: begin
        if (accept) begin
          mode_r       <= in_mode;
          c_name_r     <= in_key_name[NAME_W-1:0];
          c_phone_r    <= in_phone_number;
          size_r       <= used_size;
          k_r          <= '0;
          res_status_r <= lpht_pkg::ST_NOT_FOUND;
          res_phone_r  <= '0;
          res_comps_r  <= '0;
          res_slot_r   <= '0;
        end
      end
      lpht_pkg::S_HMOD: begin
        if (mod_done) begin
          c_home_r <= mod_rem;
          idx_r    <= AW'(mod_rem);
        end
      end
      lpht_pkg::S_CHECK: begin
        if (mode_r == lpht_pkg::MODE_INSERT) begin
          if (!cur_valid) begin
            res_status_r <= lpht_pkg::ST_INSERTED;
            res_comps_r  <= k_r[lpht_pkg::OUT_IDX_W-1:0];
            res_slot_r   <= idx_ext[lpht_pkg::OUT_IDX_W-1:0];
          end else if (replace_r) begin
            occ_name_r  <= rd_name;
            occ_phone_r <= rd_phone;
          end else if (last) begin
            res_status_r <= lpht_pkg::ST_FULL;
          end
        end else if (hit) begin
          res_status_r <= lpht_pkg::ST_FOUND;
          res_phone_r  <= rd_phone;
          res_comps_r  <= k_r[lpht_pkg::OUT_IDX_W-1:0];
          res_slot_r   <= idx_ext[lpht_pkg::OUT_IDX_W-1:0];
        end
        if (chk_step) begin
          k_r   <= k_r + SW'(1);
          idx_r <= idx_nxt;
        end
      end
      lpht_pkg::S_OMOD: begin
        if (mod_done) begin
          // misplaced occupant: it becomes the carried entry
          if (swap) begin
            c_name_r  <= occ_name_r;
            c_phone_r <= occ_phone_r;
            c_home_r  <= mod_rem;
          end
          if (last) begin
            res_status_r <= lpht_pkg::ST_FULL;
          end else begin
            k_r   <= k_r + SW'(1);
            idx_r <= idx_nxt;
          end
        end
      end
      lpht_pkg::S_READ, lpht_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == lpht_pkg::S_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if ((state_r == lpht_pkg::S_DONE) && out_free) begin
      out_status_r <= res_status_r;
      out_phone_r  <= res_phone_r;
      out_comps_r  <= res_comps_r;
      out_slot_r   <= res_slot_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_phone = out_phone_r;
  assign out_comparisons = out_comps_r;
  assign out_slot_index  = out_slot_r;

  // Name/phone store
  lpht_ram #(
    .WIDTH (DATA_W),
    .DEPTH (SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata ({c_name_r, c_phone_r}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared modulo unit for home slots
  lpht_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  // Checks
  `LPHT_ASSERT_IMP(a_idx_in_range, clk, rst_n, (state_r == lpht_pkg::S_CHECK),
                   (idx_ext < size_r), "probe index beyond size in use")
  `LPHT_ASSERT_IMP(a_probe_count, clk, rst_n, (state_r == lpht_pkg::S_CHECK),
                   (k_r < size_r), "probe count beyond size in use")
  `LPHT_ASSERT_NXT(a_write_sets_valid, clk, rst_n, ram_we,
                   valid_r[$past(idx_r)], "written slot not marked valid")
  `LPHT_ASSERT_NXT(a_result_issued, clk, rst_n,
                   ((state_r == lpht_pkg::S_DONE) && out_free),
                   (out_valid_r && !in_stall), "finished result not presented")

endmodule
